// File: rtl/rwp_pkg.sv
// rwp_pkg: shared types and constants for the RSN / WPA element parser
// no dependencies; imported by rwp_parse, rwp_result_buf, rsn_wpa_ie_parser and the testbench
`default_nettype none

package rwp_pkg;

    // longest element accepted before the overlong error is raised
    localparam int MAX_IE_BYTES = 257;
    localparam int POS_W        = $clog2(MAX_IE_BYTES + 1);

    localparam int CIPHER_W = 5;
    localparam int AKM_W    = 2;
    localparam int CAPS_W   = 16;

    // one parse result
    typedef struct packed {
        logic                status;
        logic                is_wpa;
        logic                group_valid;
        logic [CIPHER_W-1:0] grp_cipher;
        logic                pairwise_valid;
        logic [CIPHER_W-1:0] pairwise_ciphers;
        logic                akm_valid;
        logic [AKM_W-1:0]    akm_suites;
        logic                caps_valid;
        logic [CAPS_W-1:0]   capabilities;
    } rwp_result_t;

endpackage

`default_nettype wire

// File: rtl/rwp_parse.sv
// rwp_parse: per-byte parse state and the result built on the final byte
// depends on rwp_pkg
`default_nettype none

module rwp_parse (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                take,
    input  wire logic [7:0]          data_byte,
    input  wire logic                last_byte,
    output rwp_pkg::rwp_result_t     result
);
    import rwp_pkg::*;

    typedef enum logic [3:0] {
        PH_ID     = 4'd0,
        PH_HDR    = 4'd1,
        PH_GROUP  = 4'd2,
        PH_PCNT   = 4'd3,
        PH_PLIST  = 4'd4,
        PH_PZERO  = 4'd5,
        PH_AKCNT  = 4'd6,
        PH_AKLIST = 4'd7,
        PH_AKZERO = 4'd8,
        PH_CAPS   = 4'd9,
        PH_TAIL   = 4'd10
    } phase_t;

    localparam logic [POS_W-1:0] POS_MAX = POS_W'(MAX_IE_BYTES);
    localparam logic [23:0]      OUI_RSN = 24'h000fac;
    localparam logic [23:0]      OUI_WPA = 24'h0050f2;

    phase_t              phase_reg, phase_next;
    logic [POS_W-1:0]    pos_reg, pos_next;
    logic                wpa_reg, wpa_next;
    logic                herr_reg, herr_next;
    logic [15:0]         count_reg, count_next;
    logic [1:0]          seen_reg, seen_next;
    logic [23:0]         window_reg, window_next;
    logic [CIPHER_W-1:0] group_reg, group_next;
    logic [CIPHER_W-1:0] pair_reg, pair_next;
    logic [AKM_W-1:0]    akm_reg, akm_next;
    logic [CAPS_W-1:0]   caps_reg, caps_next;

    logic                oui_match;
    logic                oui_bad;
    logic [15:0]         count_full;
    logic [15:0]         count_dec;
    logic [CIPHER_W-1:0] cipher_hit;
    logic [AKM_W-1:0]    akm_hit;
    logic                pv, av;

    // suite selector decode against the variant oui
    always_comb
    begin
        oui_match = (window_reg == (wpa_reg ? OUI_WPA : OUI_RSN));
        case (data_byte)
            8'd0:    cipher_hit = 5'b00001;
            8'd1:    cipher_hit = 5'b00010;
            8'd2:    cipher_hit = 5'b00100;
            8'd4:    cipher_hit = 5'b01000;
            8'd5:    cipher_hit = 5'b10000;
            default: cipher_hit = '0;
        endcase
        case (data_byte)
            8'd1:    akm_hit = 2'b01;
            8'd2:    akm_hit = 2'b10;
            default: akm_hit = '0;
        endcase
        if (!oui_match)
        begin
            cipher_hit = '0;
            akm_hit    = '0;
        end
    end

    // wpa header oui check, bytes two to five
    always_comb
    begin
        case (pos_reg)
            POS_W'(2): oui_bad = (data_byte != 8'h00);
            POS_W'(3): oui_bad = (data_byte != 8'h50);
            POS_W'(4): oui_bad = (data_byte != 8'hf2);
            POS_W'(5): oui_bad = (data_byte != 8'h01);
            default:   oui_bad = 1'b0;
        endcase
    end

    assign count_full = (seen_reg == 2'd0) ? {8'h00, data_byte} : {data_byte, count_reg[7:0]};
    assign count_dec  = count_reg - 16'd1;

    // next parse state for one byte
    always_comb
    begin
        phase_next  = phase_reg;
        pos_next    = pos_reg;
        wpa_next    = wpa_reg;
        herr_next   = herr_reg;
        count_next  = count_reg;
        seen_next   = seen_reg;
        window_next = window_reg;
        group_next  = group_reg;
        pair_next   = pair_reg;
        akm_next    = akm_reg;
        caps_next   = caps_reg;

        if (pos_reg >= POS_MAX)
        begin
            herr_next = 1'b1;
        end
        else
        begin
            pos_next = pos_reg + POS_W'(1);
            if (!herr_reg)
            begin
                case (phase_reg)
                    PH_ID:
                    begin
                        if (data_byte == 8'h30)
                            wpa_next = 1'b0;
                        else if (data_byte == 8'hdd)
                            wpa_next = 1'b1;
                        else
                            herr_next = 1'b1;
                        phase_next = PH_HDR;
                    end
                    PH_HDR:
                    begin
                        if (wpa_reg && oui_bad)
                            herr_next = 1'b1;
                        if (pos_reg >= (wpa_reg ? POS_W'(7) : POS_W'(3)))
                        begin
                            phase_next  = PH_GROUP;
                            seen_next   = 2'd0;
                            window_next = '0;
                        end
                    end
                    PH_GROUP, PH_PLIST, PH_AKLIST:
                    begin
                        if (seen_reg != 2'd3)
                        begin
                            window_next = {window_reg[15:0], data_byte};
                            seen_next   = seen_reg + 2'd1;
                        end
                        else
                        begin
                            seen_next = 2'd0;
                            if (phase_reg == PH_GROUP)
                            begin
                                group_next = cipher_hit;
                                phase_next = PH_PCNT;
                            end
                            else
                            begin
                                count_next = count_dec;
                                if (phase_reg == PH_PLIST)
                                    pair_next = pair_reg | cipher_hit;
                                else
                                    akm_next = akm_reg | akm_hit;
                                if (count_dec == 16'd0)
                                    phase_next = (phase_reg == PH_PLIST) ? PH_AKCNT : PH_CAPS;
                            end
                        end
                    end
                    PH_PCNT, PH_AKCNT:
                    begin
                        count_next = count_full;
                        if (seen_reg == 2'd0)
                        begin
                            seen_next = 2'd1;
                        end
                        else
                        begin
                            seen_next = 2'd0;
                            if (phase_reg == PH_PCNT)
                                phase_next = (count_full == 16'd0) ? PH_PZERO : PH_PLIST;
                            else
                                phase_next = (count_full == 16'd0) ? PH_AKZERO : PH_AKLIST;
                        end
                    end
                    PH_CAPS:
                    begin
                        if (seen_reg == 2'd0)
                        begin
                            caps_next = {8'h00, data_byte};
                            seen_next = 2'd1;
                        end
                        else
                        begin
                            caps_next  = {data_byte, caps_reg[7:0]};
                            seen_next  = 2'd0;
                            phase_next = PH_TAIL;
                        end
                    end
                    PH_TAIL:
                    begin
                        seen_next = 2'd1;
                    end
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    // result as seen after the final byte
    always_comb
    begin
        result        = '0;
        result.is_wpa = wpa_next;
        pv            = 1'b0;
        av            = 1'b0;
        if (herr_next || phase_next <= PH_GROUP)
        begin
            result.status = 1'b1;
        end
        else
        begin
            pv = (phase_next >= PH_PLIST);
            av = (phase_next >= PH_AKLIST);
            result.group_valid    = 1'b1;
            result.grp_cipher     = group_next;
            result.pairwise_valid = pv;
            result.akm_valid      = av;
            result.caps_valid     = (phase_next == PH_TAIL);
            if (pv && phase_next != PH_PLIST)
                result.pairwise_ciphers = pair_next;
            if (av && phase_next != PH_AKLIST && phase_next != PH_AKZERO)
                result.akm_suites = akm_next;
            if (phase_next == PH_TAIL)
                result.capabilities = caps_next;
            case (phase_next)
                PH_PCNT, PH_AKCNT:
                    result.status = (seen_next != 2'd0);
                PH_PLIST, PH_AKLIST, PH_AKZERO:
                    result.status = 1'b1;
                PH_CAPS, PH_TAIL:
                    result.status = (seen_next != 2'd0) && wpa_next;
                default:
                    result.status = 1'b0;
            endcase
        end
    end

    // state register, back to reset after each element
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_ID;
            pos_reg    <= '0;
            wpa_reg    <= 1'b0;
            herr_reg   <= 1'b0;
            count_reg  <= '0;
            seen_reg   <= '0;
            window_reg <= '0;
            group_reg  <= '0;
            pair_reg   <= '0;
            akm_reg    <= '0;
            caps_reg   <= '0;
        end
        else if (take)
        begin
            if (last_byte)
            begin
                phase_reg  <= PH_ID;
                pos_reg    <= '0;
                wpa_reg    <= 1'b0;
                herr_reg   <= 1'b0;
                count_reg  <= '0;
                seen_reg   <= '0;
                window_reg <= '0;
                group_reg  <= '0;
                pair_reg   <= '0;
                akm_reg    <= '0;
                caps_reg   <= '0;
            end
            else
            begin
                phase_reg  <= phase_next;
                pos_reg    <= pos_next;
                wpa_reg    <= wpa_next;
                herr_reg   <= herr_next;
                count_reg  <= count_next;
                seen_reg   <= seen_next;
                window_reg <= window_next;
                group_reg  <= group_next;
                pair_reg   <= pair_next;
                akm_reg    <= akm_next;
                caps_reg   <= caps_next;
            end
        end
    end

endmodule

`default_nettype wire

// File: rtl/rwp_result_buf.sv
// rwp_result_buf: output register that holds one result until it is taken
// depends on rwp_pkg
`default_nettype none

module rwp_result_buf (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                load,
    input  wire rwp_pkg::rwp_result_t load_data,
    output logic                     full_stalled,
    output logic                     out_valid,
    input  wire logic                out_stall,
    output rwp_pkg::rwp_result_t     out_data
);
    import rwp_pkg::*;

    logic        valid_reg;
    rwp_result_t data_reg;

    assign full_stalled = valid_reg && out_stall;
    assign out_valid    = valid_reg;
    assign out_data     = data_reg;

    // valid flag: set on load, cleared once the transaction completes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (load)
            valid_reg <= 1'b1;
        else if (!out_stall)
            valid_reg <= 1'b0;
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (load)
            data_reg <= load_data;
    end

endmodule

`default_nettype wire

// File: rtl/rsn_wpa_ie_parser.sv
// rsn_wpa_ie_parser: top level of the RSN / WPA information element parser
// depends on rwp_pkg, rwp_parse, rwp_result_buf
//
//  channel | direction | handshake           | payload
//  --------+-----------+---------------------+------------------------------------------
//  in      | input     | in_valid, in_stall  | data_byte, last_byte
//  out     | output    | out_valid, out_stall| status, is_wpa, group/pairwise/akm/caps
//
// one element byte is taken per cycle; parse state updates at the same edge
// the result of an element is registered at the edge that takes its last byte
// and shows on out the next cycle
// in_stall is high only while a result waits in the output register and
// out_stall is high; otherwise a byte can be taken every cycle
// reset clears the parse state and the output valid flag at once
`default_nettype none

module rsn_wpa_ie_parser (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [7:0]  data_byte,
    input  wire logic        last_byte,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic             status,
    output logic             is_wpa,
    output logic             group_valid,
    output logic [4:0]       grp_cipher,
    output logic             pairwise_valid,
    output logic [4:0]       pairwise_ciphers,
    output logic             akm_valid,
    output logic [1:0]       akm_suites,
    output logic             caps_valid,
    output logic [15:0]      capabilities
);
    import rwp_pkg::*;

    logic        take;
    logic        full_stalled;
    rwp_result_t step_result;
    rwp_result_t out_data;

    assign in_stall = full_stalled;
    assign take     = in_valid && !full_stalled;

    // byte-wise parser
    rwp_parse u_parse (
        .clk       (clk),
        .rst_n     (rst_n),
        .take      (take),
        .data_byte (data_byte),
        .last_byte (last_byte),
        .result    (step_result)
    );

    // result register
    rwp_result_buf u_result_buf (
        .clk          (clk),
        .rst_n        (rst_n),
        .load         (take && last_byte),
        .load_data    (step_result),
        .full_stalled (full_stalled),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .out_data     (out_data)
    );

    // unpack result fields
    assign status           = out_data.status;
    assign is_wpa           = out_data.is_wpa;
    assign group_valid      = out_data.group_valid;
    assign grp_cipher       = out_data.grp_cipher;
    assign pairwise_valid   = out_data.pairwise_valid;
    assign pairwise_ciphers = out_data.pairwise_ciphers;
    assign akm_valid        = out_data.akm_valid;
    assign akm_suites       = out_data.akm_suites;
    assign caps_valid       = out_data.caps_valid;
    assign capabilities     = out_data.capabilities;

`ifndef ASSERT_OFF
    // a final byte taken always yields a result the next cycle
    a_last_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall && last_byte) |=> out_valid)
        else $error("final byte taken but no result");

    // an accepted element always has its group cipher parsed
    a_ok_has_group: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !status) |-> group_valid)
        else $error("accepted element without group cipher");

    // fields become valid in element order
    a_valid_order: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> ((!akm_valid || pairwise_valid) && (!caps_valid || akm_valid)
                       && (!pairwise_valid || group_valid)))
        else $error("field valid bits out of order");

    // an unparsed group cipher or capabilities field reads as zero
    a_unparsed_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> ((caps_valid || capabilities == 16'h0000)
                       && (group_valid || grp_cipher == 5'd0)))
        else $error("unparsed field not zero");
`endif

endmodule

`default_nettype wire

// File: verif/rsn_wpa_ie_parser_tb.sv
// rsn_wpa_ie_parser_tb: self-checking testbench for the RSN / WPA element parser
// drives elements byte by byte and checks each result against the directed table or an in-bench predictor
// depends on rwp_pkg and rsn_wpa_ie_parser
`timescale 1ns / 1ps

module rsn_wpa_ie_parser_tb;

    import rwp_pkg::*;

    // element ids, suite selectors and suite type codes
    localparam logic [7:0]  ID_RSN      = 8'h30;
    localparam logic [7:0]  ID_WPA      = 8'hdd;
    localparam logic [23:0] RSN_OUI     = 24'h000fac;
    localparam logic [23:0] WPA_OUI     = 24'h0050f2;
    localparam logic [31:0] WPA_HDR_TAG = 32'h0050f201;

    localparam logic [7:0] SUITE_NONE   = 8'd0;
    localparam logic [7:0] SUITE_WEP40  = 8'd1;
    localparam logic [7:0] SUITE_TKIP   = 8'd2;
    localparam logic [7:0] SUITE_CCMP   = 8'd4;
    localparam logic [7:0] SUITE_WEP104 = 8'd5;
    localparam logic [7:0] AKM_8021X    = 8'd1;
    localparam logic [7:0] AKM_PSK      = 8'd2;

    localparam logic [4:0] CIPH_NONE   = 5'b00001;
    localparam logic [4:0] CIPH_WEP40  = 5'b00010;
    localparam logic [4:0] CIPH_TKIP   = 5'b00100;
    localparam logic [4:0] CIPH_CCMP   = 5'b01000;
    localparam logic [4:0] CIPH_WEP104 = 5'b10000;
    localparam logic [1:0] AKMB_8021X  = 2'b01;
    localparam logic [1:0] AKMB_PSK    = 2'b10;

    localparam int CYCLE_LIMIT = 500000;
    localparam int HOLD_LEN    = 400;
    localparam int MAX_GAP     = 40;

    typedef enum logic [3:0] {
        PH_ELEM_ID,
        PH_HEADER,
        PH_GROUP_SUITE,
        PH_PAIR_COUNT,
        PH_PAIR_LIST,
        PH_PAIR_NONE,
        PH_AKM_COUNT,
        PH_AKM_LIST,
        PH_AKM_NONE,
        PH_CAPS_WORD,
        PH_TRAILER
    } ie_phase_e;

    // result typed into the directed table, or predicted when known is 0
    typedef struct packed {
        logic        known;
        rwp_result_t want;
    } table_result_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [7:0]  data_byte = 8'h00;
    logic        last_byte = 1'b0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic        status;
    logic        is_wpa;
    logic        group_valid;
    logic [4:0]  grp_cipher;
    logic        pairwise_valid;
    logic [4:0]  pairwise_ciphers;
    logic        akm_valid;
    logic [1:0]  akm_suites;
    logic        caps_valid;
    logic [15:0] capabilities;

    // predictor state
    int unsigned ie_pos;
    ie_phase_e   ie_phase;
    logic        ie_wpa;
    logic        ie_err;
    logic [15:0] ie_count;
    int unsigned ie_seen;
    logic [23:0] ie_window;
    logic [4:0]  ie_group;
    logic [4:0]  ie_pair;
    logic [1:0]  ie_akm;
    logic [15:0] ie_caps;

    rwp_result_t   pending_results[$];
    table_result_t table_results[$];
    logic [7:0]    elem_q[$];
    string         dir_hex[$];
    table_result_t dir_want[$];

    int error_count = 0;
    int cycle_count = 0;
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int hold_request = 0;
    int hold_seen = 0;
    int hold_left = 0;
    int bytes_sent = 0;
    int elements_sent = 0;
    int longest_element = 0;
    int results_seen = 0;
    int ok_results = 0;
    int bad_results = 0;
    int wpa_results = 0;

    rsn_wpa_ie_parser i_dut (.*);

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // run limit
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, pending_results.size());
            $display("Some tests failed");
            $finish;
        end
    end

    task automatic report_error(input string msg);
        error_count++;
        if (error_count <= 40)
            $display("ERROR @%0t: %s", $realtime, msg);
    endtask

    // ---------------------------------------------------------------
    // predictor
    // ---------------------------------------------------------------

    function automatic void ie_clear();
        ie_pos    = 0;
        ie_phase  = PH_ELEM_ID;
        ie_wpa    = 1'b0;
        ie_err    = 1'b0;
        ie_count  = '0;
        ie_seen   = 0;
        ie_window = '0;
        ie_group  = '0;
        ie_pair   = '0;
        ie_akm    = '0;
        ie_caps   = '0;
    endfunction

    function automatic logic [4:0] cipher_of(input logic [7:0] kind);
        if (ie_window != (ie_wpa ? WPA_OUI : RSN_OUI))
            return '0;
        case (kind)
            SUITE_NONE:   return CIPH_NONE;
            SUITE_WEP40:  return CIPH_WEP40;
            SUITE_TKIP:   return CIPH_TKIP;
            SUITE_CCMP:   return CIPH_CCMP;
            SUITE_WEP104: return CIPH_WEP104;
            default:      return '0;
        endcase
    endfunction

    function automatic logic [1:0] akm_of(input logic [7:0] kind);
        if (ie_window != (ie_wpa ? WPA_OUI : RSN_OUI))
            return '0;
        if (kind == AKM_8021X)
            return AKMB_8021X;
        if (kind == AKM_PSK)
            return AKMB_PSK;
        return '0;
    endfunction

    // the three oui bytes shift into the window, the fourth byte completes the suite
    function automatic bit gather_suite(input logic [7:0] b);
        if (ie_seen < 3)
        begin
            ie_window = {ie_window[15:0], b};
            ie_seen++;
            return 1'b0;
        end
        ie_seen = 0;
        return 1'b1;
    endfunction

    // little-endian 16-bit count
    function automatic bit gather_count(input logic [7:0] b);
        if (ie_seen == 0)
        begin
            ie_count = {8'h00, b};
            ie_seen  = 1;
            return 1'b0;
        end
        ie_count[15:8] = b;
        ie_seen = 0;
        return 1'b1;
    endfunction

    function automatic void ie_take(input logic [7:0] b);
        int unsigned hdr_len;
        int unsigned pos;
        hdr_len = ie_wpa ? 8 : 4;
        pos     = ie_pos;
        // overlong element
        if (pos >= MAX_IE_BYTES)
        begin
            ie_err = 1'b1;
            return;
        end
        ie_pos = pos + 1;
        if (ie_err)
            return;
        case (ie_phase)
            PH_ELEM_ID:
            begin
                if (b == ID_RSN)
                    ie_wpa = 1'b0;
                else if (b == ID_WPA)
                    ie_wpa = 1'b1;
                else
                    ie_err = 1'b1;
                ie_phase = PH_HEADER;
            end
            PH_HEADER:
            begin
                if (ie_wpa && pos >= 2 && pos <= 5 && b != WPA_HDR_TAG[31 - 8 * (pos - 2) -: 8])
                    ie_err = 1'b1;
                if (pos + 1 >= hdr_len)
                begin
                    ie_phase  = PH_GROUP_SUITE;
                    ie_seen   = 0;
                    ie_window = '0;
                end
            end
            PH_GROUP_SUITE:
            begin
                if (gather_suite(b))
                begin
                    ie_group = cipher_of(b);
                    ie_phase = PH_PAIR_COUNT;
                end
            end
            PH_PAIR_COUNT:
            begin
                if (gather_count(b))
                    ie_phase = (ie_count == 0) ? PH_PAIR_NONE : PH_PAIR_LIST;
            end
            PH_PAIR_LIST:
            begin
                if (gather_suite(b))
                begin
                    ie_pair  = ie_pair | cipher_of(b);
                    ie_count = ie_count - 16'd1;
                    if (ie_count == 0)
                        ie_phase = PH_AKM_COUNT;
                end
            end
            PH_AKM_COUNT:
            begin
                if (gather_count(b))
                    ie_phase = (ie_count == 0) ? PH_AKM_NONE : PH_AKM_LIST;
            end
            PH_AKM_LIST:
            begin
                if (gather_suite(b))
                begin
                    ie_akm   = ie_akm | akm_of(b);
                    ie_count = ie_count - 16'd1;
                    if (ie_count == 0)
                        ie_phase = PH_CAPS_WORD;
                end
            end
            PH_CAPS_WORD:
            begin
                if (ie_seen == 0)
                begin
                    ie_caps = {8'h00, b};
                    ie_seen = 1;
                end
                else
                begin
                    ie_caps[15:8] = b;
                    ie_seen  = 0;
                    ie_phase = PH_TRAILER;
                end
            end
            PH_TRAILER:
                ie_seen = 1;
            default:
                ;
        endcase
    endfunction

    function automatic rwp_result_t ie_result();
        rwp_result_t r;
        ie_phase_e   ph;
        bit          stray;
        r        = '0;
        ph       = ie_phase;
        stray    = (ie_seen != 0);
        r.is_wpa = ie_wpa;
        if (ie_err || ph <= PH_GROUP_SUITE)
            r.status = 1'b1;
        else
        begin
            r.group_valid    = 1'b1;
            r.grp_cipher     = ie_group;
            r.pairwise_valid = (ph >= PH_PAIR_LIST);
            r.akm_valid      = (ph >= PH_AKM_LIST);
            r.caps_valid     = (ph == PH_TRAILER);
            r.status = (ph == PH_PAIR_COUNT && stray) || ph == PH_PAIR_LIST
                    || (ph == PH_AKM_COUNT && stray) || ph == PH_AKM_LIST
                    || ph == PH_AKM_NONE
                    || ((ph == PH_CAPS_WORD || ph == PH_TRAILER) && stray && ie_wpa);
            if (r.pairwise_valid && ph != PH_PAIR_LIST)
                r.pairwise_ciphers = ie_pair;
            if (r.akm_valid && ph != PH_AKM_LIST && ph != PH_AKM_NONE)
                r.akm_suites = ie_akm;
            if (r.caps_valid)
                r.capabilities = ie_caps;
        end
        return r;
    endfunction

    // one accepted byte; returns 1 with the result when it closes the element
    function automatic bit ie_step(input logic [7:0] b, input logic fin,
                                   output rwp_result_t r);
        r = '0;
        ie_take(b);
        if (!fin)
            return 1'b0;
        r = ie_result();
        ie_clear();
        return 1'b1;
    endfunction

    // ---------------------------------------------------------------
    // checking
    // ---------------------------------------------------------------

    task automatic check_field(input string name, input int unsigned got,
                               input int unsigned want);
        if (got != want)
            report_error($sformatf("result %0d field %s: got %0h expected %0h",
                                   results_seen, name, got, want));
    endtask

    task automatic check_result(input rwp_result_t got, input rwp_result_t want);
        check_field("status", got.status, want.status);
        check_field("is_wpa", got.is_wpa, want.is_wpa);
        check_field("group_valid", got.group_valid, want.group_valid);
        check_field("grp_cipher", got.grp_cipher, want.grp_cipher);
        check_field("pairwise_valid", got.pairwise_valid, want.pairwise_valid);
        check_field("pairwise_ciphers", got.pairwise_ciphers, want.pairwise_ciphers);
        check_field("akm_valid", got.akm_valid, want.akm_valid);
        check_field("akm_suites", got.akm_suites, want.akm_suites);
        check_field("caps_valid", got.caps_valid, want.caps_valid);
        check_field("capabilities", got.capabilities, want.capabilities);
    endtask

    // result and byte transactions, sampled at the rising edge
    always @(posedge clk)
    begin
        rwp_result_t   got;
        rwp_result_t   predicted;
        table_result_t row;
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                got.status           = status;
                got.is_wpa           = is_wpa;
                got.group_valid      = group_valid;
                got.grp_cipher       = grp_cipher;
                got.pairwise_valid   = pairwise_valid;
                got.pairwise_ciphers = pairwise_ciphers;
                got.akm_valid        = akm_valid;
                got.akm_suites       = akm_suites;
                got.caps_valid       = caps_valid;
                got.capabilities     = capabilities;
                if (pending_results.size() == 0)
                    report_error("result with no element outstanding");
                else
                    check_result(got, pending_results.pop_front());
                results_seen++;
                if (got.status)
                    bad_results++;
                else
                    ok_results++;
                if (got.is_wpa)
                    wpa_results++;
            end
            if (in_valid && !in_stall)
            begin
                if (ie_step(data_byte, last_byte, predicted))
                begin
                    row = table_results.pop_front();
                    pending_results.push_back(row.known ? row.want : predicted);
                end
            end
        end
    end

    // ---------------------------------------------------------------
    // receiver: random stall plus an occasional long hold-off
    // ---------------------------------------------------------------

    always @(negedge clk)
    begin
        if (hold_seen != hold_request)
        begin
            hold_seen = hold_request;
            hold_left = HOLD_LEN;
        end
        if (hold_left != 0)
        begin
            hold_left--;
            out_stall <= 1'b1;
        end
        else
            out_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    // ---------------------------------------------------------------
    // sender
    // ---------------------------------------------------------------

    // entered and left at a falling edge
    task automatic push_byte(input logic [7:0] b, input logic fin);
        int gap;
        gap = 0;
        while (gap < MAX_GAP && $urandom_range(99) < send_idle_pct)
            gap++;
        repeat (gap)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid  <= 1'b1;
        data_byte <= b;
        last_byte <= fin;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        bytes_sent++;
        @(negedge clk);
    endtask

    task automatic send_element(input table_result_t known);
        table_results.push_back(known);
        foreach (elem_q[i])
            push_byte(elem_q[i], i == elem_q.size() - 1);
        elements_sent++;
        if (elem_q.size() > longest_element)
            longest_element = elem_q.size();
    endtask

    // pause the sender until every result is back; entered at a falling edge
    task automatic drain();
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    // ---------------------------------------------------------------
    // element builders
    // ---------------------------------------------------------------

    function automatic void load_hex(input string s);
        logic [7:0] c;
        logic [7:0] acc;
        int         nib;
        int         digits;
        elem_q.delete();
        acc    = '0;
        digits = 0;
        for (int i = 0; i < s.len(); i++)
        begin
            c = s[i];
            if (c >= "0" && c <= "9")
                nib = c - "0";
            else if (c >= "a" && c <= "f")
                nib = c - "a" + 10;
            else
                nib = -1;
            if (nib >= 0)
            begin
                acc = {acc[3:0], 4'(nib)};
                digits++;
                if (digits == 2)
                begin
                    elem_q.push_back(acc);
                    digits = 0;
                end
            end
        end
    endfunction

    function automatic logic [7:0] maybe_corrupt(input logic [7:0] b, input int pct);
        return ($urandom_range(99) < pct) ? 8'($urandom) : b;
    endfunction

    function automatic void add_suite(input logic [23:0] oui, input bit for_akm);
        elem_q.push_back(maybe_corrupt(oui[23:16], 4));
        elem_q.push_back(maybe_corrupt(oui[15:8], 4));
        elem_q.push_back(maybe_corrupt(oui[7:0], 4));
        if ($urandom_range(99) < 80)
            elem_q.push_back(8'($urandom_range(for_akm ? 3 : 6)));
        else
            elem_q.push_back(8'($urandom));
    endfunction

    function automatic void add_count(input int n);
        elem_q.push_back(8'(n));
        // now and then a huge count that the element cannot hold
        elem_q.push_back(($urandom_range(99) < 3) ? 8'($urandom) : 8'h00);
    endfunction

    // mostly well-formed elements with random content, some cut short or noise
    function automatic void build_random_element(input int pad_to, input bit force_rsn);
        bit          wpa;
        logic [23:0] oui;
        int          npair;
        int          nakm;
        int          keep;
        elem_q.delete();
        if (pad_to == 0 && $urandom_range(99) < 5)
        begin
            repeat ($urandom_range(1, 12))
                elem_q.push_back(8'($urandom));
            if ($urandom_range(1))
                elem_q[0] = $urandom_range(1) ? ID_RSN : ID_WPA;
            return;
        end
        wpa = !force_rsn && $urandom_range(1);
        oui = wpa ? WPA_OUI : RSN_OUI;
        elem_q.push_back(wpa ? ID_WPA : ID_RSN);
        elem_q.push_back(8'h00);
        if (wpa)
            for (int i = 0; i < 4; i++)
                elem_q.push_back(maybe_corrupt(WPA_HDR_TAG[31 - 8 * i -: 8], 3));
        elem_q.push_back(8'($urandom));
        elem_q.push_back(8'($urandom));
        if ($urandom_range(99) < 92)
        begin
            add_suite(oui, 1'b0);
            if ($urandom_range(99) < 92)
            begin
                npair = ($urandom_range(99) < 12) ? 0 : $urandom_range(1, 3);
                add_count(npair);
                repeat (npair)
                    add_suite(oui, 1'b0);
                if (npair != 0 && $urandom_range(99) < 90)
                begin
                    nakm = ($urandom_range(99) < 10) ? 0 : $urandom_range(1, 2);
                    add_count(nakm);
                    repeat (nakm)
                        add_suite(oui, 1'b1);
                    if ($urandom_range(99) < 75)
                    begin
                        elem_q.push_back(8'($urandom));
                        elem_q.push_back(8'($urandom));
                    end
                end
                if ($urandom_range(99) < 25)
                    repeat ($urandom_range(1, 3))
                        elem_q.push_back(8'($urandom));
            end
        end
        while (elem_q.size() < pad_to)
            elem_q.push_back(8'($urandom));
        // broken element: cut anywhere
        if (pad_to == 0 && $urandom_range(99) < 15)
        begin
            keep = $urandom_range(1, elem_q.size());
            while (elem_q.size() > keep)
                void'(elem_q.pop_back());
        end
        if (elem_q.size() > 1)
            elem_q[1] = ($urandom_range(99) < 90) ? 8'(elem_q.size() - 2) : 8'($urandom);
    endfunction

    // ---------------------------------------------------------------
    // directed table
    // ---------------------------------------------------------------

    function automatic rwp_result_t result_of(
        input logic st, input logic wpa, input logic gv, input logic [4:0] gc,
        input logic pv, input logic [4:0] pc, input logic av, input logic [1:0] ak,
        input logic cv, input logic [15:0] caps);
        rwp_result_t r;
        r.status           = st;
        r.is_wpa           = wpa;
        r.group_valid      = gv;
        r.grp_cipher       = gc;
        r.pairwise_valid   = pv;
        r.pairwise_ciphers = pc;
        r.akm_valid        = av;
        r.akm_suites       = ak;
        r.caps_valid       = cv;
        r.capabilities     = caps;
        return r;
    endfunction

    function automatic void add_row(input string hex, input rwp_result_t want,
                                    input bit known);
        table_result_t row;
        row.known = known;
        row.want  = want;
        dir_hex.push_back(hex);
        dir_want.push_back(row);
    endfunction

    function automatic void build_table();
        // unknown ids at both extremes
        add_row("00", result_of(1, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1);
        add_row("ff 00", result_of(1, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1);
        // header cut short
        add_row("30 02 01", result_of(1, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1);
        // wpa with the wrong oui type
        add_row("dd 16 00 50 f2 02 01 00 00 50 f2 04",
                result_of(1, 1, 0, 0, 0, 0, 0, 0, 0, 0), 1);
        // group suite cut short
        add_row("30 06 01 00 00 0f ac", result_of(1, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1);
        // group suite only
        add_row("30 06 01 00 00 0f ac 04",
                result_of(0, 0, 1, CIPH_CCMP, 0, 0, 0, 0, 0, 0), 1);
        // stray byte where the pairwise count should be
        add_row("30 07 01 00 00 0f ac 02 01",
                result_of(1, 0, 1, CIPH_TKIP, 0, 0, 0, 0, 0, 0), 1);
        // pairwise count zero, the rest ignored
        add_row("30 0a 01 00 00 0f ac 04 00 00 01 02 03 04",
                result_of(0, 0, 1, CIPH_CCMP, 1, 0, 0, 0, 0, 0), 1);
        // pairwise list cut short
        add_row("30 0c 01 00 00 0f ac 04 02 00 00 0f ac 04 00 0f",
                result_of(1, 0, 1, CIPH_CCMP, 1, 0, 0, 0, 0, 0), 1);
        // every cipher, both key management suites, capabilities all ones
        add_row({"30 28 01 00 00 0f ac 05 05 00 00 0f ac 00 00 0f ac 01 00 0f ac 02 ",
                 "00 0f ac 04 00 0f ac 05 02 00 00 0f ac 01 00 0f ac 02 ff ff"}, '0, 0);
        // key management count zero
        add_row("30 0e 01 00 00 0f ac 04 01 00 00 0f ac 04 00 00",
                result_of(1, 0, 1, CIPH_CCMP, 1, CIPH_CCMP, 1, 0, 0, 0), 1);
        // stray byte where the key management count should be
        add_row("30 0f 01 00 00 0f ac 04 01 00 00 0f ac 04 01", '0, 0);
        // key management list cut short
        add_row("30 13 01 00 00 0f ac 04 01 00 00 0f ac 04 01 00 00 0f ac", '0, 0);
        // rsn without capabilities, then one stray byte, then trailing bytes
        add_row("30 14 01 00 00 0f ac 04 01 00 00 0f ac 04 01 00 00 0f ac 02", '0, 0);
        add_row("30 15 01 00 00 0f ac 04 01 00 00 0f ac 04 01 00 00 0f ac 02 0c", '0, 0);
        add_row({"30 18 01 00 00 0f ac 04 01 00 00 0f ac 04 01 00 00 0f ac 02 ",
                 "00 00 dd ee"}, '0, 0);
        // wpa without capabilities, then one stray byte, then trailing bytes
        add_row({"dd 16 00 50 f2 01 01 00 00 50 f2 02 01 00 00 50 f2 02 01 00 ",
                 "00 50 f2 02"}, '0, 0);
        add_row({"dd 17 00 50 f2 01 01 00 00 50 f2 02 01 00 00 50 f2 02 01 00 ",
                 "00 50 f2 02 00"}, '0, 0);
        add_row({"dd 19 00 50 f2 01 01 00 00 50 f2 02 01 00 00 50 f2 02 01 00 ",
                 "00 50 f2 02 3c 00 7f"}, '0, 0);
        // wpa pairwise count zero with junk after it
        add_row("dd 0e 00 50 f2 01 01 00 00 50 f2 02 00 00 aa bb", '0, 0);
        // rsn carrying wpa selectors
        add_row({"30 14 01 00 00 50 f2 04 01 00 00 50 f2 04 01 00 00 50 f2 01 ",
                 "00 00"}, '0, 0);
        // all ones after the id
        add_row("30 ff ff ff ff ff ff ff ff ff ff ff", '0, 0);
        // wpa with 802.1x and capabilities all ones
        add_row({"dd 18 00 50 f2 01 00 00 00 50 f2 00 01 00 00 50 f2 01 01 00 ",
                 "00 50 f2 01 ff ff"}, '0, 0);
        // unknown suite types
        add_row({"30 1a 01 00 00 0f ac 03 02 00 00 0f ac 06 00 0f ac ff 01 00 ",
                 "00 0f ac 00 80 00"}, '0, 0);
    endfunction

    // ---------------------------------------------------------------
    // main sequence
    // ---------------------------------------------------------------

    initial
    begin
        int idle_by_phase[4];
        int stall_by_phase[4];
        int start_bytes;
        int start_elems;
        idle_by_phase  = '{0, 84, 0, 13};
        stall_by_phase = '{0, 0, 84, 13};
        ie_clear();
        build_table();

        repeat (10)
            @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed elements, no idling
        foreach (dir_hex[i])
        begin
            load_hex(dir_hex[i]);
            send_element(dir_want[i]);
        end

        // random elements over the idling phases
        for (int phase = 0; phase < 4; phase++)
        begin
            drain();
            send_idle_pct  = idle_by_phase[phase];
            recv_stall_pct = stall_by_phase[phase];
            // long receiver hold-off while the sender keeps going
            if (phase == 0)
                hold_request++;
            @(negedge clk);
            if (phase == 0)
            begin
                // longest legal element, then one byte over
                build_random_element(MAX_IE_BYTES, 1'b1);
                send_element('0);
                build_random_element(MAX_IE_BYTES + 1, 1'b0);
                send_element('0);
            end
            start_bytes = bytes_sent;
            start_elems = elements_sent;
            while (phase != 0
                   && (bytes_sent - start_bytes < 50 || elements_sent - start_elems < 3))
            begin
                build_random_element(0, 1'b0);
                send_element('0);
            end
        end

        drain();
        repeat (20)
            @(posedge clk);
        if (pending_results.size() != 0)
            report_error($sformatf("%0d results never arrived", pending_results.size()));

        $display("covered %0d elements (%0d bytes, longest %0d) over four idling phases",
                 elements_sent, bytes_sent, longest_element);
        $display("%0d results checked: %0d accepted, %0d malformed, %0d wpa; %0d errors",
                 results_seen, ok_results, bad_results, wpa_results, error_count);
        if (error_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
